// File: rtl/core/qmn_pkg.sv
// shared types, constants and helpers of the quaternion multiply-normalize unit
`default_nettype none
package qmn_pkg;

  localparam int unsigned FracBitsDef = 30;
  localparam int unsigned ElemW       = 32;

  typedef struct packed {
    logic signed [ElemW-1:0] a_w;
    logic signed [ElemW-1:0] a_x;
    logic signed [ElemW-1:0] a_y;
    logic signed [ElemW-1:0] a_z;
    logic signed [ElemW-1:0] b_w;
    logic signed [ElemW-1:0] b_x;
    logic signed [ElemW-1:0] b_y;
    logic signed [ElemW-1:0] b_z;
  } req_t;

  typedef struct packed {
    logic signed [ElemW-1:0] p_w;
    logic signed [ElemW-1:0] p_x;
    logic signed [ElemW-1:0] p_y;
    logic signed [ElemW-1:0] p_z;
    logic                    zero_norm;
  } res_t;

  // bit length of an 8-bit chunk, 0..8
  function automatic logic [3:0] bit_len8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < 8; k++) begin
      if (v[k]) n = 4'(k + 1);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/quaternion_multiply_normalize_unit.sv
// top level: pipelined quaternion product, normalized to unit length
//
// usage: a request (two quaternions, signed fixed point with FRAC_BITS
// fraction bits) is taken at each rising edge where start_i is high and
// busy_o is low. busy_o is always low: the pipeline takes one request per
// cycle, back to back, with no gaps needed.
// each request gives one result on res_o, marked by done_o for one cycle,
// after it passes the product and normalize stages, the 32-stage square
// root pipeline, the FRAC_BITS + 2 stage restoring divider pipelines (one
// quotient bit each) and the output register.
// throughput is one result per cycle.
// a product of exactly zero gives the identity and raises zero_norm.
// reset clears all valid bits; data registers are not reset. results in
// flight at reset are dropped. the receiver cannot stall: results leave in
// order, one per cycle.
`default_nettype none
module quaternion_multiply_normalize_unit #(
  parameter int unsigned FRAC_BITS = qmn_pkg::FracBitsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire qmn_pkg::req_t req_i,
  output logic               done_o,
  output qmn_pkg::res_t      res_o
);

  localparam int unsigned QB  = FRAC_BITS + 2;   // quotient bits
  localparam int unsigned NW  = FRAC_BITS + 32;  // numerator width
  localparam int unsigned SQS = 32;              // root stages
  localparam logic [31:0] MagMax = 32'h7FFF_FFFF;
  localparam logic [31:0] OneVal = 32'(64'd1 << FRAC_BITS);

  assign busy_o = 1'b0;

  // stage 1: sixteen products
  logic               v1_q;
  logic signed [63:0] pr_q [16];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    pr_q[0]  <= 64'(req_i.a_w * req_i.b_w);
    pr_q[1]  <= 64'(req_i.a_x * req_i.b_x);
    pr_q[2]  <= 64'(req_i.a_y * req_i.b_y);
    pr_q[3]  <= 64'(req_i.a_z * req_i.b_z);
    pr_q[4]  <= 64'(req_i.a_w * req_i.b_x);
    pr_q[5]  <= 64'(req_i.b_w * req_i.a_x);
    pr_q[6]  <= 64'(req_i.a_y * req_i.b_z);
    pr_q[7]  <= 64'(req_i.a_z * req_i.b_y);
    pr_q[8]  <= 64'(req_i.a_w * req_i.b_y);
    pr_q[9]  <= 64'(req_i.b_w * req_i.a_y);
    pr_q[10] <= 64'(req_i.a_z * req_i.b_x);
    pr_q[11] <= 64'(req_i.a_x * req_i.b_z);
    pr_q[12] <= 64'(req_i.a_w * req_i.b_z);
    pr_q[13] <= 64'(req_i.b_w * req_i.a_z);
    pr_q[14] <= 64'(req_i.a_x * req_i.b_y);
    pr_q[15] <= 64'(req_i.a_y * req_i.b_x);
  end

  // stage 2: pairwise sums with the signs of the product rule
  logic               v2_q;
  logic signed [65:0] h_q [8];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    h_q[0] <= 66'(pr_q[0]) - 66'(pr_q[1]);
    h_q[1] <= -66'(pr_q[2]) - 66'(pr_q[3]);
    h_q[2] <= 66'(pr_q[4]) + 66'(pr_q[5]);
    h_q[3] <= 66'(pr_q[7]) - 66'(pr_q[6]);
    h_q[4] <= 66'(pr_q[8]) + 66'(pr_q[9]);
    h_q[5] <= 66'(pr_q[11]) - 66'(pr_q[10]);
    h_q[6] <= 66'(pr_q[12]) + 66'(pr_q[13]);
    h_q[7] <= 66'(pr_q[15]) - 66'(pr_q[14]);
  end

  // stage 3: exact components
  logic               v3_q;
  logic signed [65:0] c_q [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) c_q[i] <= h_q[2*i] + h_q[2*i+1];
  end

  // stage 4: sign and magnitude
  logic        v4_q;
  logic [3:0]  ng4_q;
  logic [64:0] mg4_q [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      ng4_q[i] <= c_q[i][65];
      mg4_q[i] <= c_q[i][65] ? 65'(-c_q[i]) : 65'(c_q[i]);
    end
  end

  // stage 5: per-chunk bit length of the or of all magnitudes
  logic        v5_q;
  logic [3:0]  ng5_q;
  logic [64:0] mg5_q [4];
  logic [3:0]  lb5_q [9];
  logic [64:0] or4;
  always_comb begin
    or4 = mg4_q[0] | mg4_q[1] | mg4_q[2] | mg4_q[3];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else         v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    ng5_q <= ng4_q;
    for (int i = 0; i < 4; i++) mg5_q[i] <= mg4_q[i];
    for (int k = 0; k < 8; k++) lb5_q[k] <= qmn_pkg::bit_len8(or4[8*k +: 8]);
    lb5_q[8] <= {3'd0, or4[64]};
  end

  // stage 6: overall bit length
  logic        v6_q;
  logic [3:0]  ng6_q;
  logic [64:0] mg6_q [4];
  logic [6:0]  bl6_q;
  logic [6:0]  bl5;
  always_comb begin
    bl5 = 7'd0;
    for (int k = 0; k < 9; k++) begin
      if (lb5_q[k] != 4'd0) bl5 = 7'(8 * k) + 7'(lb5_q[k]);
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else         v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    ng6_q <= ng5_q;
    bl6_q <= bl5;
    for (int i = 0; i < 4; i++) mg6_q[i] <= mg5_q[i];
  end

  // stage 7: coarse normalizing shift, multiples of eight
  logic        v7_q;
  logic [3:0]  ng7_q;
  logic [2:0]  fs7_q;
  logic        z7_q;
  logic [95:0] x7_q [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else         v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    ng7_q <= ng6_q;
    fs7_q <= bl6_q[2:0];
    z7_q  <= (bl6_q == 7'd0);
    for (int i = 0; i < 4; i++) begin
      x7_q[i] <= {mg6_q[i], 31'd0} >> {bl6_q[6:3], 3'd0};
    end
  end

  // stage 8: fine shift, leaves the largest in [2^30, 2^31)
  logic        v8_q;
  logic [3:0]  ng8_q;
  logic        z8_q;
  logic [30:0] m8_q [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else         v8_q <= v7_q;
  end
  always_ff @(posedge clk_i) begin
    ng8_q <= ng7_q;
    z8_q  <= z7_q;
    for (int i = 0; i < 4; i++) m8_q[i] <= 31'(x7_q[i] >> fs7_q);
  end

  // stage 9: squares
  logic        v9_q;
  logic [3:0]  ng9_q;
  logic        z9_q;
  logic [30:0] m9_q [4];
  logic [61:0] sq9_q [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v9_q <= 1'b0;
    else         v9_q <= v8_q;
  end
  always_ff @(posedge clk_i) begin
    ng9_q <= ng8_q;
    z9_q  <= z8_q;
    for (int i = 0; i < 4; i++) begin
      m9_q[i]  <= m8_q[i];
      sq9_q[i] <= 62'(m8_q[i]) * 62'(m8_q[i]);
    end
  end

  // stage 10 and root pipeline: one root bit per stage
  logic        rv_q  [SQS+1];
  logic [3:0]  rng_q [SQS+1];
  logic        rz_q  [SQS+1];
  logic [30:0] rm_q  [SQS+1][4];
  logic [63:0] rs_q  [SQS+1];
  logic [33:0] rr_q  [SQS+1];
  logic [31:0] rq_q  [SQS+1];
  logic [35:0] r_in  [SQS];
  logic [35:0] r_try [SQS];

  always_comb begin
    for (int j = 0; j < SQS; j++) begin
      r_in[j]  = {rr_q[j], rs_q[j][63:62]};
      r_try[j] = {2'd0, rq_q[j], 2'b01};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= SQS; j++) rv_q[j] <= 1'b0;
    end else begin
      rv_q[0] <= v9_q;
      for (int j = 0; j < SQS; j++) rv_q[j+1] <= rv_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    rng_q[0] <= ng9_q;
    rz_q[0]  <= z9_q;
    for (int i = 0; i < 4; i++) rm_q[0][i] <= m9_q[i];
    rs_q[0]  <= 64'(sq9_q[0]) + 64'(sq9_q[1]) + 64'(sq9_q[2]) + 64'(sq9_q[3]);
    rr_q[0]  <= 34'd0;
    rq_q[0]  <= 32'd0;
    for (int j = 0; j < SQS; j++) begin
      rng_q[j+1] <= rng_q[j];
      rz_q[j+1]  <= rz_q[j];
      for (int i = 0; i < 4; i++) rm_q[j+1][i] <= rm_q[j][i];
      rs_q[j+1]  <= {rs_q[j][61:0], 2'b00};
      if (r_in[j] >= r_try[j]) begin
        rr_q[j+1] <= 34'(r_in[j] - r_try[j]);
        rq_q[j+1] <= {rq_q[j][30:0], 1'b1};
      end else begin
        rr_q[j+1] <= 34'(r_in[j]);
        rq_q[j+1] <= {rq_q[j][30:0], 1'b0};
      end
    end
  end

  // divider pipelines: rounded numerator, then one quotient bit per stage
  logic          dv_q  [QB+1];
  logic [3:0]    dng_q [QB+1];
  logic          dz_q  [QB+1];
  logic [31:0]   dn_q  [QB+1];
  logic [31:0]   drm_q [QB+1][4];
  logic [QB-1:0] dnl_q [QB+1][4];
  logic [QB-1:0] dqt_q [QB+1][4];
  logic [NW-1:0] num   [4];
  logic [32:0]   d_in  [QB][4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num[i] = {rm_q[SQS][i], FRAC_BITS'(0)} + NW'(rq_q[SQS] >> 1);
    end
    for (int j = 0; j < QB; j++) begin
      for (int i = 0; i < 4; i++) d_in[j][i] = {drm_q[j][i], dnl_q[j][i][QB-1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= QB; j++) dv_q[j] <= 1'b0;
    end else begin
      dv_q[0] <= rv_q[SQS];
      for (int j = 0; j < QB; j++) dv_q[j+1] <= dv_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    dng_q[0] <= rng_q[SQS];
    dz_q[0]  <= rz_q[SQS];
    dn_q[0]  <= rq_q[SQS];
    for (int i = 0; i < 4; i++) begin
      drm_q[0][i] <= 32'(num[i][NW-1:QB]);
      dnl_q[0][i] <= num[i][QB-1:0];
      dqt_q[0][i] <= '0;
    end
    for (int j = 0; j < QB; j++) begin
      dng_q[j+1] <= dng_q[j];
      dz_q[j+1]  <= dz_q[j];
      dn_q[j+1]  <= dn_q[j];
      for (int i = 0; i < 4; i++) begin
        dnl_q[j+1][i] <= dnl_q[j][i] << 1;
        if (d_in[j][i] >= {1'b0, dn_q[j]}) begin
          drm_q[j+1][i] <= 32'(d_in[j][i] - {1'b0, dn_q[j]});
          dqt_q[j+1][i] <= {dqt_q[j][i][QB-2:0], 1'b1};
        end else begin
          drm_q[j+1][i] <= 32'(d_in[j][i]);
          dqt_q[j+1][i] <= {dqt_q[j][i][QB-2:0], 1'b0};
        end
      end
    end
  end

  // output: clamp, apply sign, identity on a zero product
  logic          done_q;
  qmn_pkg::res_t res_q;
  logic [31:0]   qs [4];
  logic [31:0]   pe [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qs[i] = (33'(dqt_q[QB][i]) > 33'(MagMax)) ? MagMax : 32'(dqt_q[QB][i]);
      pe[i] = dng_q[QB][i] ? 32'(-qs[i]) : qs[i];
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= dv_q[QB];
  end
  always_ff @(posedge clk_i) begin
    if (dz_q[QB]) begin
      res_q.p_w       <= OneVal;
      res_q.p_x       <= '0;
      res_q.p_y       <= '0;
      res_q.p_z       <= '0;
      res_q.zero_norm <= 1'b1;
    end else begin
      res_q.p_w       <= pe[0];
      res_q.p_x       <= pe[1];
      res_q.p_y       <= pe[2];
      res_q.p_z       <= pe[3];
      res_q.zero_norm <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire
